// File: rtl/cubic_bspline_point_table_eval_assert.svh
// Assertion macros for the cubic B-spline point table evaluator.
// Used by the top level; needs clk and rst in the including scope.
`ifndef CUBIC_BSPLINE_POINT_TABLE_EVAL_ASSERT_SVH
`define CUBIC_BSPLINE_POINT_TABLE_EVAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bsp_pkg.sv
// Shared types and constants of the cubic B-spline point table evaluator.
// No dependencies; imported by bsp_mul, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W   = 32;
  localparam int PIDX_W    = 8;
  localparam int T_W       = 17;
  localparam int U_FRAC    = 16;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int OUT_CNT_W = 9;
  localparam int SQ_W      = 64;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 152;

  localparam logic [T_W-1:0] ONE_U = T_W'(1) << U_FRAC;

  localparam int P_W      = T_W + CNT_W;
  localparam int SEG_HI_W = P_W - U_FRAC;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int W_W    = 33;
  localparam int ACC_W  = 66;
  localparam int NUM_W  = 52;
  localparam int DER_W  = 36;

  localparam int WDEN_SH = 19;
  localparam logic [NUM_W-1:0] WHALF  = NUM_W'(3) << 18;
  localparam logic [MUL_W-1:0] RECIP3 = 34'h0AAAAAAAB;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_MOVE    = 3'd1,
    OP_POINT   = 3'd2,
    OP_TANGENT = 3'd3,
    OP_NEAREST = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_FEW_POINTS = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

endpackage

`default_nettype wire

// File: rtl/bsp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the control point coordinates.
`timescale 1ns / 1ps
`default_nettype none

module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/bsp_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bsp_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module bsp_mul import bsp_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// File: rtl/cubic_bspline_point_table_eval.sv
// Top level of the cubic B-spline point table evaluator: sequencer and datapath.
// Depends on bsp_pkg, bsp_ram, bsp_mul and the assertion macro header.
//
// The block takes one command transaction on the s_ channel and returns exactly one
// result transaction on the m_ channel. The opcode travels in s_tuser and the status
// in m_tuser. Commands append or move a control point, evaluate the curve or its
// derivative at t, or search the table for the point nearest to a given point.
// One command is worked on at a time and s_tready is low until it is finished.
// Every product goes through one shared multiplier, so the multiply count sets the
// time. An append or a move writes the memories and then loads the result, while an
// error or an unused opcode loads it directly. A curve point or tangent finds the
// segment and weights, then weighs four control points in turn; a nearest search
// scores each stored point in turn. The sequencer then returns to idle for the next
// command. The result sits in an output register; a new command is accepted while
// it waits, and a stalled receiver only holds the sequencer once the next result
// is ready. Reset empties the table, clears m_tvalid and returns the sequencer to
// idle; the coordinate memories are not cleared and need no clearing time.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bspline_point_table_eval_assert.svh"

module cubic_bspline_point_table_eval import bsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // point_index[7:0], point_x[39:8], point_y[71:40], t_param[88:72], zeros above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[2:0]
  input  logic [OP_W-1:0]       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x[31:0], out_y[63:32], nearest_index[71:64], distance_sq[135:72],
  // count_now[144:136], zeros above
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[2:0]
  output logic [ST_W-1:0]       m_tuser
);

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_SEG, S_SEGR, S_SQ_U, S_CUBE_U, S_SQ_V, S_CUBE_V, S_CAP,
    S_WNUM, S_WQ, S_WQR, S_WDER, S_RD, S_MX, S_MY, S_MACC, S_RND,
    S_NRD, S_NDX, S_NDY, S_NCMP, S_DONE
  } state_t;

  state_t state;

  op_t                        op;
  logic [PIDX_W-1:0]          idx;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;
  logic [T_W-1:0]             t_sat;
  logic [CNT_W-1:0]           cnt;
  logic [IDX_W-1:0]           c0;
  logic [T_W-1:0]             uu;
  logic [T_W-1:0]             vv;
  logic [32:0]                u2;
  logic [32:0]                v2;
  logic [48:0]                u3;
  logic [48:0]                v3;
  logic [COORD_W-1:0]         wnum [4];
  logic signed [W_W-1:0]      w [4];
  logic [1:0]                 k;
  logic [CNT_W-1:0]           i;
  logic signed [ACC_W-1:0]    acc_x;
  logic signed [ACC_W-1:0]    acc_y;
  logic signed [COORD_W-1:0]  y_hold;
  logic [32:0]                dy;
  logic [SQ_W-1:0]            sx;
  logic [SQ_W-1:0]            best;
  logic [PIDX_W-1:0]          nidx;
  status_t                    res_status;
  logic [COORD_W-1:0]         res_x;
  logic [COORD_W-1:0]         res_y;
  logic [PIDX_W-1:0]          res_idx;
  logic [SQ_W-1:0]            res_dist;

  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_addr;
  logic signed [COORD_W-1:0]  x_rd;
  logic signed [COORD_W-1:0]  y_rd;

  logic [CNT_W-1:0]           segs_m1;
  logic [P_W-1:0]             p_seg;
  logic [SEG_HI_W-1:0]        c0_sel;
  logic [P_W-1:0]             u_full;
  logic [NUM_W-1:0]           n0;
  logic [NUM_W-1:0]           n1;
  logic [NUM_W-1:0]           n2;
  logic [NUM_W-1:0]           n3;
  logic [NUM_W-1:0]           t3u3;
  logic [NUM_W-1:0]           u2s;
  logic [DER_W-1:0]           d0;
  logic [DER_W-1:0]           d1;
  logic [DER_W-1:0]           d2;
  logic [DER_W-1:0]           d3;
  logic signed [32:0]         dxs;
  logic signed [32:0]         dys;
  logic [32:0]                dx_abs;
  logic [32:0]                dy_abs;
  logic [SQ_W:0]              sq_sum;
  logic [SQ_W-1:0]            d_cur;
  logic                       upd;
  logic [SQ_W-1:0]            best_new;
  logic [PIDX_W-1:0]          nidx_new;

  logic [T_W-1:0]             in_t;
  logic [PIDX_W-1:0]          in_idx;

  function automatic logic signed [W_W-1:0] rnd_away(input logic [DER_W-1:0] x);
    logic [DER_W-1:0] mag;
    logic [DER_W-1:0] q;
    mag = x[DER_W-1] ? ('0 - x) : x;
    q   = (mag + DER_W'(4)) >> 3;
    return x[DER_W-1] ? ('0 - W_W'(q)) : W_W'(q);
  endfunction

  function automatic logic [COORD_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] r;
    s = a + $signed(ACC_W'(1) << 29);
    r = s >>> 30;
    if (r[ACC_W-1:COORD_W-1] == '0 || r[ACC_W-1:COORD_W-1] == '1) begin
      return r[COORD_W-1:0];
    end else if (r[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  bsp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  bsp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (px),
    .rdata (x_rd)
  );

  bsp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (py),
    .rdata (y_rd)
  );

  assign s_tready = (state == S_IDLE);
  assign in_t     = s_tdata[88:72];
  assign in_idx   = s_tdata[7:0];

  always_comb begin
    segs_m1 = cnt - CNT_W'(4);
    p_seg   = prod[P_W-1:0];
    if (p_seg[P_W-1:U_FRAC] > SEG_HI_W'(segs_m1)) begin
      c0_sel = SEG_HI_W'(segs_m1);
    end else begin
      c0_sel = p_seg[P_W-1:U_FRAC];
    end
    u_full = p_seg - {c0_sel, {U_FRAC{1'b0}}};

    t3u3 = (NUM_W'(u3) << 1) + NUM_W'(u3);
    u2s  = NUM_W'(u2) << U_FRAC;
    n0   = NUM_W'(v3);
    n1   = (NUM_W'(1) << 50) + t3u3 - ((u2s << 2) + (u2s << 1));
    n2   = (NUM_W'(1) << 48) + (NUM_W'(uu) << 33) + (NUM_W'(uu) << 32)
         + (u2s << 1) + u2s - t3u3;
    n3   = NUM_W'(u3);

    d0 = '0 - DER_W'(v2);
    d1 = (DER_W'(u2) << 1) + DER_W'(u2) - (DER_W'(uu) << 18);
    d2 = (DER_W'(1) << 32) + (DER_W'(uu) << 17) - (DER_W'(u2) << 1) - DER_W'(u2);
    d3 = DER_W'(u2);

    dxs    = 33'(x_rd) - 33'(px);
    dys    = 33'(y_rd) - 33'(py);
    dx_abs = dxs[32] ? ('0 - dxs) : dxs;
    dy_abs = dys[32] ? ('0 - dys) : dys;

    sq_sum   = {1'b0, sx} + {1'b0, prod[SQ_W-1:0]};
    d_cur    = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    upd      = (i == '0) || (d_cur < best);
    best_new = upd ? d_cur : best;
    nidx_new = upd ? i[PIDX_W-1:0] : nidx;
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    ram_we   = 1'b0;
    ram_addr = '0;
    case (state)
      S_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = (op == OP_APPEND) ? cnt[IDX_W-1:0] : IDX_W'(idx);
      end
      S_SEG: begin
        mul_a = MUL_W'(t_sat);
        mul_b = MUL_W'(cnt - CNT_W'(3));
      end
      S_SQ_U: begin
        mul_a = MUL_W'(uu);
        mul_b = MUL_W'(uu);
      end
      S_CUBE_U: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(uu);
      end
      S_SQ_V: begin
        mul_a = MUL_W'(vv);
        mul_b = MUL_W'(vv);
      end
      S_CUBE_V: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(vv);
      end
      S_WQ: begin
        mul_a = MUL_W'(wnum[k]);
        mul_b = RECIP3;
      end
      S_RD: begin
        ram_addr = c0 + IDX_W'(k);
      end
      S_MX: begin
        mul_a = MUL_W'(x_rd);
        mul_b = MUL_W'(w[k]);
      end
      S_MY: begin
        mul_a = MUL_W'(y_hold);
        mul_b = MUL_W'(w[k]);
      end
      S_NRD: begin
        ram_addr = i[IDX_W-1:0];
      end
      S_NDX: begin
        mul_a = MUL_W'(dx_abs);
        mul_b = MUL_W'(dx_abs);
      end
      S_NDY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= op_t'(s_tuser);
            idx        <= in_idx;
            px         <= s_tdata[39:8];
            py         <= s_tdata[71:40];
            t_sat      <= (in_t > ONE_U) ? ONE_U : in_t;
            res_status <= ST_OK;
            res_x      <= '0;
            res_y      <= '0;
            res_idx    <= '0;
            res_dist   <= '0;
            i          <= '0;
            case (op_t'(s_tuser))
              OP_APPEND: begin
                if (cnt >= CNT_W'(MAX_POINTS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_WRITE;
                end
              end
              OP_MOVE: begin
                if (CNT_W'(in_idx) >= cnt) begin
                  res_status <= ST_BAD_INDEX;
                  state      <= S_DONE;
                end else begin
                  state <= S_WRITE;
                end
              end
              OP_POINT, OP_TANGENT: begin
                if (cnt < CNT_W'(4)) begin
                  res_status <= ST_FEW_POINTS;
                  state      <= S_DONE;
                end else begin
                  state <= S_SEG;
                end
              end
              OP_NEAREST: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_NRD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WRITE: begin
          if (op == OP_APPEND) begin
            cnt <= cnt + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SEG: begin
          state <= S_SEGR;
        end
        S_SEGR: begin
          c0    <= IDX_W'(c0_sel);
          uu    <= u_full[T_W-1:0];
          vv    <= ONE_U - u_full[T_W-1:0];
          acc_x <= '0;
          acc_y <= '0;
          state <= S_SQ_U;
        end
        S_SQ_U: begin
          state <= S_CUBE_U;
        end
        S_CUBE_U: begin
          u2    <= prod[32:0];
          state <= S_SQ_V;
        end
        S_SQ_V: begin
          u3    <= prod[48:0];
          state <= S_CUBE_V;
        end
        S_CUBE_V: begin
          v2    <= prod[32:0];
          state <= S_CAP;
        end
        S_CAP: begin
          v3    <= prod[48:0];
          k     <= '0;
          state <= (op == OP_TANGENT) ? S_WDER : S_WNUM;
        end
        S_WNUM: begin
          wnum[0] <= COORD_W'((n0 + WHALF) >> WDEN_SH);
          wnum[1] <= COORD_W'((n1 + WHALF) >> WDEN_SH);
          wnum[2] <= COORD_W'((n2 + WHALF) >> WDEN_SH);
          wnum[3] <= COORD_W'((n3 + WHALF) >> WDEN_SH);
          state   <= S_WQ;
        end
        S_WQ: begin
          state <= S_WQR;
        end
        S_WQR: begin
          w[k]  <= W_W'(prod[63:33]);
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? S_RD : S_WQ;
        end
        S_WDER: begin
          w[0]  <= rnd_away(d0);
          w[1]  <= rnd_away(d1);
          w[2]  <= rnd_away(d2);
          w[3]  <= rnd_away(d3);
          state <= S_RD;
        end
        S_RD: begin
          state <= S_MX;
        end
        S_MX: begin
          y_hold <= y_rd;
          state  <= S_MY;
        end
        S_MY: begin
          acc_x <= acc_x + prod[ACC_W-1:0];
          state <= S_MACC;
        end
        S_MACC: begin
          acc_y <= acc_y + prod[ACC_W-1:0];
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? S_RND : S_RD;
        end
        S_RND: begin
          res_x <= rnd_sat(acc_x);
          res_y <= rnd_sat(acc_y);
          state <= S_DONE;
        end
        S_NRD: begin
          state <= S_NDX;
        end
        S_NDX: begin
          dy    <= dy_abs;
          state <= S_NDY;
        end
        S_NDY: begin
          sx    <= prod[SQ_W-1:0];
          state <= S_NCMP;
        end
        S_NCMP: begin
          best <= best_new;
          nidx <= nidx_new;
          i    <= i + CNT_W'(1);
          if (i + CNT_W'(1) == cnt) begin
            res_dist <= best_new;
            res_idx  <= nidx_new;
            state    <= S_DONE;
          end else begin
            state <= S_NRD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_DATA_W - 145){1'b0}}, OUT_CNT_W'(cnt), res_dist,
                         res_idx, res_y, res_x};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSP_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CNT_W'(MAX_POINTS), "point count above table size")
  `BSP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `BSP_ASSERT_NOW(a_out_count, m_tvalid, m_tdata[144:136] <= OUT_CNT_W'(MAX_POINTS), "bad count out")

endmodule

`default_nettype wire

// File: dv/cubic_bspline_point_table_eval_test.sv
// Self-checking testbench for the cubic B-spline point table evaluator.
// Drives commands on the s_ channel, predicts each result and checks the m_ channel.
// Depends on bsp_pkg and the RTL of cubic_bspline_point_table_eval.
`timescale 1ns / 1ps

module cubic_bspline_point_table_eval_test;
  import bsp_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [7:0] nearest_index;
    logic [63:0] distance_sq;
    logic [8:0] count_now;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [ST_W-1:0] m_tuser;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int mismatch_count = 0;
  int result_count = 0;
  int command_count = 0;
  int op_seen [0:7];

  logic signed [31:0] model_x [0:MAX_POINTS-1];
  logic signed [31:0] model_y [0:MAX_POINTS-1];
  int unsigned model_count = 0;
  result_t pending_results [$];

  cubic_bspline_point_table_eval u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint div_away8(longint num);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + 4) / 8;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [31:0] round_sat_q16(logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + (128'sd1 <<< 29)) >>> 30;
    if (r > 128'sd2147483647) r = 128'sd2147483647;
    if (r < -128'sd2147483648) r = -128'sd2147483648;
    return r[31:0];
  endfunction

  task automatic curve_at(logic [16:0] t_in, bit deriv, output logic [31:0] ox,
                          output logic [31:0] oy);
    longint unsigned segs, t, p, c0, uu, ss, vv, s3, u2, u3;
    longint w [0:3];
    logic signed [127:0] ax, ay;
    segs = model_count - 3;
    t = t_in > 65536 ? 65536 : t_in;
    p = t * segs;
    c0 = p >> 16;
    if (c0 > segs - 1) c0 = segs - 1;
    uu = p - (c0 << 16);
    ss = 65536;
    vv = ss - uu;
    if (!deriv) begin
      s3 = ss * ss * ss;
      u2 = uu * uu;
      u3 = u2 * uu;
      w[0] = (vv * vv * vv + (3 << 18)) / (6 << 18);
      w[1] = (4 * s3 + 3 * u3 - 6 * u2 * ss + (3 << 18)) / (6 << 18);
      w[2] = (s3 + 3 * uu * ss * ss + 3 * u2 * ss - 3 * u3 + (3 << 18)) / (6 << 18);
      w[3] = (u3 + (3 << 18)) / (6 << 18);
    end else begin
      w[0] = div_away8(-longint'(vv * vv));
      w[1] = div_away8(3 * longint'(uu * uu) - 4 * longint'(uu * ss));
      w[2] = div_away8(longint'(ss * ss) + 2 * longint'(uu * ss) - 3 * longint'(uu * uu));
      w[3] = div_away8(longint'(uu * uu));
    end
    ax = 0;
    ay = 0;
    for (int k = 0; k < 4; k++) begin
      ax += 128'(model_x[(c0 + k) % MAX_POINTS]) * 128'(w[k]);
      ay += 128'(model_y[(c0 + k) % MAX_POINTS]) * 128'(w[k]);
    end
    ox = round_sat_q16(ax);
    oy = round_sat_q16(ay);
  endtask

  task automatic predict_command(logic [2:0] op, logic [7:0] idx, logic signed [31:0] px,
                                 logic signed [31:0] py, logic [16:0] t);
    result_t r;
    longint unsigned dx, dy, sx, sy, d, best;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (model_count >= MAX_POINTS) r.status = ST_FULL;
        else begin
          model_x[model_count] = px;
          model_y[model_count] = py;
          model_count++;
        end
      end
      OP_MOVE: begin
        if (idx >= model_count) r.status = ST_BAD_INDEX;
        else begin
          model_x[idx] = px;
          model_y[idx] = py;
        end
      end
      OP_POINT, OP_TANGENT: begin
        if (model_count < 4) r.status = ST_FEW_POINTS;
        else curve_at(t, op == OP_TANGENT, r.out_x, r.out_y);
      end
      OP_NEAREST: begin
        if (model_count == 0) r.status = ST_EMPTY;
        else begin
          best = 0;
          for (int i = 0; i < model_count; i++) begin
            dx = longint'(model_x[i]) - longint'(px);
            dy = longint'(model_y[i]) - longint'(py);
            if (longint'(dx) < 0) dx = -dx;
            if (longint'(dy) < 0) dy = -dy;
            sx = dx * dx;
            sy = dy * dy;
            d = (sx > 64'hFFFF_FFFF_FFFF_FFFF - sy) ? 64'hFFFF_FFFF_FFFF_FFFF : sx + sy;
            if (i == 0 || d < best) begin
              best = d;
              r.nearest_index = i[7:0];
            end
          end
          r.distance_sq = best;
        end
      end
      default: ;
    endcase
    r.count_now = model_count[8:0];
    pending_results = {pending_results, r};
  endtask

  task automatic send_command(logic [2:0] op, logic [7:0] idx, logic [31:0] px,
                              logic [31:0] py, logic [16:0] t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, t, py, px, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(op, idx, px, py, t);
    command_count++;
    op_seen[op]++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        result_t got, want;
        got.status = m_tuser;
        got.out_x = m_tdata[31:0];
        got.out_y = m_tdata[63:32];
        got.nearest_index = m_tdata[71:64];
        got.distance_sq = m_tdata[135:72];
        got.count_now = m_tdata[144:136];
        result_count++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(2000) - 1000;
      3: return ($urandom_range(400) - 200) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] random_t();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF - 17'($urandom_range(3));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic test_empty_table();
    send_command(OP_NEAREST, 8'd0, 32'd5, 32'd5, 17'd0);
    send_command(OP_POINT, 8'd0, 32'd0, 32'd0, 17'd100);
    send_command(OP_TANGENT, 8'd0, 32'd0, 32'd0, 17'd100);
    send_command(OP_MOVE, 8'd0, 32'd1, 32'd1, 17'd0);
    for (int op = 5; op < 8; op++) send_command(3'(op), 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                 17'h1FFFF);
  endtask

  task automatic test_directed_curve();
    send_command(OP_APPEND, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 17'd0);
    send_command(OP_APPEND, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 17'd0);
    send_command(OP_APPEND, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd0);
    send_command(OP_POINT, 8'd0, 32'd0, 32'd0, 17'd0);
    send_command(OP_APPEND, 8'd0, 32'h8000_0000, 32'h8000_0000, 17'd0);
    send_command(OP_POINT, 8'd0, 32'd0, 32'd0, 17'd0);
    send_command(OP_POINT, 8'd0, 32'd0, 32'd0, 17'd65536);
    send_command(OP_TANGENT, 8'd0, 32'd0, 32'd0, 17'h1FFFF);
    send_command(OP_TANGENT, 8'd0, 32'd0, 32'd0, 17'd32768);
    send_command(OP_MOVE, 8'd4, 32'd0, 32'd0, 17'd0);
    send_command(OP_MOVE, 8'd1, 32'd0, 32'd0, 17'd0);
    send_command(OP_APPEND, 8'd0, 32'd0, 32'd0, 17'd0);
    send_command(OP_NEAREST, 8'd0, 32'd0, 32'd0, 17'd0);
    send_command(OP_NEAREST, 8'd0, 32'h8000_0000, 32'h8000_0000, 17'd0);
  endtask

  task automatic test_random_mix(int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2: op = OP_APPEND;
        3, 4, 5: op = OP_MOVE;
        6, 7, 8, 9, 10: op = OP_POINT;
        11, 12, 13, 14: op = OP_TANGENT;
        15, 16, 17: op = OP_NEAREST;
        default: op = 3'($urandom_range(7));
      endcase
      if (op == OP_APPEND && model_count > 40 && $urandom_range(3) != 0) op = OP_POINT;
      send_command(op, 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(model_count + 1)),
                   random_coord(), random_coord(), random_t());
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) send_command(OP_POINT, 8'd0, 32'd0, 32'd0, random_t());
    wait_drained();
    send_command(OP_NEAREST, 8'd0, random_coord(), random_coord(), 17'd0);
  endtask

  task automatic test_full_table();
    while (model_count < MAX_POINTS) send_command(OP_APPEND, 8'd0, random_coord(),
                                                  random_coord(), 17'd0);
    send_command(OP_APPEND, 8'd0, 32'd1, 32'd2, 17'd0);
    send_command(OP_MOVE, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 17'd0);
    send_command(OP_POINT, 8'd0, 32'd0, 32'd0, 17'd65536);
    send_command(OP_TANGENT, 8'd0, 32'd0, 32'd0, 17'd65535);
    test_random_mix(60);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed_curve();
    wait_drained();
    test_random_mix(500);
    test_backpressure();
    send_idle_pct = 71;
    test_random_mix(400);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    test_random_mix(400);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random_mix(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_full_table();
    wait_drained();
    $display("Ran %0d commands (append %0d, move %0d, point %0d, tangent %0d, nearest %0d),",
             command_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("checked %0d results with %0d mismatches, table filled to capacity.",
             result_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
